[src/ps2kd_pkg.sv]
package ps2kd_pkg;

   // Keymap geometry: three banks (plain, shifted, extended)
   localparam int BANK_SIZE = 128;
   localparam int MAP_DEPTH = 3 * BANK_SIZE;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   // one extra bit so code + 2 * BANK_SIZE never wraps
   localparam int SUM_W     = MAP_AW + 1;

   // Scan code prefixes and shift markers in the map
   localparam logic [7:0] CODE_BREAK   = 8'hF0;
   localparam logic [7:0] CODE_EXT     = 8'hE0;
   localparam logic [7:0] SHIFT_MARK_A = 8'd14;
   localparam logic [7:0] SHIFT_MARK_B = 8'd15;

   // Frame: bits 0..10, data in bits 1..8
   localparam logic [3:0] BIT_FIRST_DATA = 4'd1;
   localparam logic [3:0] BIT_LAST_DATA  = 4'd8;
   localparam logic [3:0] BIT_STOP       = 4'd10;

   // Bank codes on the result
   localparam logic [1:0] BANK_PLAIN = 2'd0;
   localparam logic [1:0] BANK_SHIFT = 2'd1;
   localparam logic [1:0] BANK_EXT   = 2'd2;

   // Request kind (req_tuser)
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_WRITE  = 1'b1;

   // Decoder phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_BRK     = 4'b0010,
      PH_EXT     = 4'b0100,
      PH_EXT_BRK = 4'b1000
   } phase_type;

   // Finished scan byte from the frame receiver
   typedef struct packed {
      logic       valid;
      logic [7:0] code;
   } issue_type;

   // Keymap read request (two ports, one enable)
   typedef struct packed {
      logic              en;
      logic [MAP_AW-1:0] addr_a;
      logic [MAP_AW-1:0] addr_b;
   } rd_req_type;

   // Keymap write request
   typedef struct packed {
      logic              en;
      logic [MAP_AW-1:0] addr;
      logic [7:0]        data;
   } wr_req_type;

endpackage

[src/ps2kd_keymap.sv]
module ps2kd_keymap
   import ps2kd_pkg::*;
(
   input  logic       clock,
   input  wr_req_type wr_req,
   input  rd_req_type rd_req,
   output logic [7:0] rd_a_data,
   output logic [7:0] rd_b_data
);

   logic [7:0] mem [MAP_DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
   end

   // two registered read ports; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_a_ff <= mem[rd_req.addr_a];
         rd_b_ff <= mem[rd_req.addr_b];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

[src/ps2kd_frame.sv]
module ps2kd_frame
   import ps2kd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      sample_en,
   input  logic      clock_line,
   input  logic      data_line,
   output issue_type issue
);

   logic       prev_clock_ff, prev_clock_in;
   logic [3:0] bit_index_ff, bit_index_in;
   logic [7:0] frame_shift_ff, frame_shift_in;
   logic       falling;

   assign falling = sample_en && prev_clock_ff && !clock_line;

   // edge detect, bit count and LSB-first shift
   always_comb begin
      prev_clock_in  = sample_en ? clock_line : prev_clock_ff;
      bit_index_in   = bit_index_ff;
      frame_shift_in = frame_shift_ff;
      if (falling) begin
         if (bit_index_ff >= BIT_FIRST_DATA && bit_index_ff <= BIT_LAST_DATA) begin
            frame_shift_in = {data_line, frame_shift_ff[7:1]};
         end
         if (bit_index_ff >= BIT_STOP) begin
            bit_index_in = '0;
         end else begin
            bit_index_in = bit_index_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_clock_ff  <= 1'b1;
         bit_index_ff   <= '0;
         frame_shift_ff <= '0;
      end else begin
         prev_clock_ff  <= prev_clock_in;
         bit_index_ff   <= bit_index_in;
         frame_shift_ff <= frame_shift_in;
      end
   end

   // stop bit edge: byte is complete, no shift on this beat
   assign issue.valid = falling && (bit_index_ff >= BIT_STOP);
   assign issue.code  = frame_shift_ff;

   bit_index_range_a: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= BIT_STOP)
      else $error("bit index past stop bit");

   issue_resets_count_a: assert property (@(posedge clock) disable iff (reset)
      issue.valid |=> bit_index_ff == '0)
      else $error("bit index not cleared after frame");

   idle_clock_no_edge_a: assert property (@(posedge clock) disable iff (reset)
      !prev_clock_ff |-> !issue.valid)
      else $error("byte issued without falling edge");

endmodule

[src/ps2kd_decode.sv]
module ps2kd_decode
   import ps2kd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  issue_type  issue,
   output rd_req_type rd_req,
   input  logic [7:0] rd_a_data,
   input  logic [7:0] rd_b_data,
   output logic       hold,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_char_code,
   output logic [7:0] rsp_scan_code,
   output logic [1:0] rsp_bank
);

   phase_type  phase_ff, phase_in;
   logic       shift_ff, shift_in;

   // byte in flight: memory data arrives in the cycle after issue
   logic       d1_ff, d1_in;
   logic [7:0] code_d1_ff;
   logic [1:0] bank_d1_ff;
   logic       oob_d1_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff;
   logic [7:0] rsp_scan_ff;
   logic [1:0] rsp_bank_ff;

   logic [1:0]       issue_bank;
   logic [SUM_W-1:0] addr_b_sum;
   logic             is_shift;
   logic             emit;
   logic             d1_fire;

   // bank for the emit read follows the phase at issue time
   always_comb begin
      case (phase_ff)
         PH_BRK:     issue_bank = shift_ff ? BANK_SHIFT : BANK_PLAIN;
         PH_EXT_BRK: issue_bank = BANK_EXT;
         default:    issue_bank = BANK_PLAIN;
      endcase
   end

   assign addr_b_sum = SUM_W'(issue.code) + SUM_W'(issue_bank) * SUM_W'(BANK_SIZE);

   assign rd_req.en     = issue.valid;
   assign rd_req.addr_a = MAP_AW'(issue.code);
   assign rd_req.addr_b = addr_b_sum[MAP_AW-1:0];

   // capture the byte alongside the memory read
   always_ff @(posedge clock) begin
      if (issue.valid) begin
         code_d1_ff <= issue.code;
         bank_d1_ff <= issue_bank;
         oob_d1_ff  <= addr_b_sum >= SUM_W'(MAP_DEPTH);
      end
   end

   assign is_shift = (rd_a_data == SHIFT_MARK_A) || (rd_a_data == SHIFT_MARK_B);

   // decode the byte; emit only on a release
   always_comb begin
      phase_in = phase_ff;
      shift_in = shift_ff;
      emit     = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (is_shift) begin
               shift_in = 1'b1;
            end else if (code_d1_ff == CODE_BREAK) begin
               phase_in = PH_BRK;
            end else if (code_d1_ff == CODE_EXT) begin
               phase_in = PH_EXT;
            end
         end
         PH_BRK: begin
            phase_in = PH_IDLE;
            if (is_shift) begin
               shift_in = 1'b0;
            end else begin
               emit = 1'b1;
            end
         end
         PH_EXT: begin
            phase_in = (code_d1_ff == CODE_BREAK) ? PH_EXT_BRK : PH_IDLE;
         end
         PH_EXT_BRK: begin
            phase_in = PH_IDLE;
            emit     = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // byte leaves stage 1 unless its result would overwrite a held one
   assign d1_fire = d1_ff && (!emit || !rsp_valid_ff || rsp_tready);
   assign d1_in   = issue.valid || (d1_ff && !d1_fire);
   assign hold    = d1_ff && rsp_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (d1_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         shift_ff     <= 1'b0;
         d1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (d1_fire) begin
            phase_ff <= phase_in;
            shift_ff <= shift_in;
         end
         d1_ff        <= d1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register; addresses past the map read as zero
   always_ff @(posedge clock) begin
      if (d1_fire && emit) begin
         rsp_char_ff <= oob_d1_ff ? 8'd0 : rd_b_data;
         rsp_scan_ff <= code_d1_ff;
         rsp_bank_ff <= bank_d1_ff;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_scan_code = rsp_scan_ff;
   assign rsp_bank      = rsp_bank_ff;

   no_overlap_a: assert property (@(posedge clock) disable iff (reset)
      issue.valid |-> !d1_ff || d1_fire)
      else $error("new byte issued while previous one waits");

   blocked_holds_a: assert property (@(posedge clock) disable iff (reset)
      d1_ff && !d1_fire |=> d1_ff && $stable(code_d1_ff))
      else $error("waiting byte lost");

   bank_legal_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_bank_ff != 2'd3)
      else $error("illegal bank on result");

endmodule

[src/ps2_keyboard_key_decoder.sv]
// The stop-bit edge beat's byte passes the keymap read register, then the result register.
// Throughput: one request beat per cycle; req_tready drops for every cycle in which a decoded
//   byte sits in the keymap read stage while a result is still held (one 2R1W keymap read
//   per byte), and stays low until the consumer takes the held result if that byte emits.
// Table writes land in the keymap at the next edge.
// Reset (synchronous, active high) clears line, frame and decode state; the keymap is not
//   cleared and holds whatever was written.
module ps2_keyboard_key_decoder
   import ps2kd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] clock_line, [1] data_line, [10:2] table_addr, [18:11] table_value, [23:19] zero
   input  logic [23:0] req_tdata,
   // [0] func
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] char_code, [15:8] scan_code, [17:16] bank, [23:18] zero
   output logic [23:0] rsp_tdata
);

   logic       accept;
   logic       clock_line;
   logic       data_line;
   logic [8:0] table_addr;
   logic [7:0] table_value;

   issue_type  issue;
   rd_req_type rd_req;
   wr_req_type wr_req;
   logic [7:0] rd_a_data;
   logic [7:0] rd_b_data;
   logic       hold;
   logic [7:0] char_code;
   logic [7:0] scan_code;
   logic [1:0] bank;

   assign clock_line  = req_tdata[0];
   assign data_line   = req_tdata[1];
   assign table_addr  = req_tdata[10:2];
   assign table_value = req_tdata[18:11];

   assign req_tready = !hold;
   assign accept     = req_tvalid && req_tready;

   // table writes past the map are dropped
   assign wr_req.en   = accept && (req_tuser == FUNC_WRITE) &&
                        (SUM_W'(table_addr) < SUM_W'(MAP_DEPTH));
   assign wr_req.addr = MAP_AW'(table_addr);
   assign wr_req.data = table_value;

   ps2kd_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .sample_en  (accept && (req_tuser == FUNC_SAMPLE)),
      .clock_line (clock_line),
      .data_line  (data_line),
      .issue      (issue)
   );

   ps2kd_keymap u_keymap (
      .clock     (clock),
      .wr_req    (wr_req),
      .rd_req    (rd_req),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   ps2kd_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .issue         (issue),
      .rd_req        (rd_req),
      .rd_a_data     (rd_a_data),
      .rd_b_data     (rd_b_data),
      .hold          (hold),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_char_code (char_code),
      .rsp_scan_code (scan_code),
      .rsp_bank      (bank)
   );

   assign rsp_tdata = {6'd0, bank, scan_code, char_code};

endmodule
